// ----- sv/adaptive_filter_sample_reconstruct_assert.svh -----
// Assertion macros for the sample reconstruction block.
`ifndef ADAPTIVE_FILTER_SAMPLE_RECONSTRUCT_ASSERT_SVH
`define ADAPTIVE_FILTER_SAMPLE_RECONSTRUCT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define AFSR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define AFSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- sv/afsr_pkg.sv -----
// Shared types and constants for the sample reconstruction block.
package afsr_pkg;
    localparam int TAPS = 8;
    localparam int RESULT_LIMIT = 8;
    localparam logic [1:0] MODE_8BIT = 2'd0;
    localparam logic [1:0] MODE_16BIT = 2'd1;
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    // One channel's filter and predictor state, one memory word.
    typedef struct packed {
        logic [TAPS-1:0][31:0] weight;
        logic [TAPS-1:0][3:0]  step;
        logic [TAPS-1:0][31:0] hist;
        logic [1:0]            sign;
        logic [31:0]           pred;
    } chan_state_t;

    // Read modify write request to the channel memory.
    typedef struct packed {
        logic        wr;
        logic [31:0] pred;
    } chan_upd_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [3:0] s);
        asr32 = 32'($signed(x) >>> s);
    endfunction
endpackage

// ----- sv/afsr_filter.sv -----
// Sign-adaptive 8-tap filter plus fixed predictor for one channel word, three stages.
module afsr_filter (
    input  logic                 aclk,
    input  logic                 start,
    input  afsr_pkg::chan_state_t st_in,
    input  logic                 clr,
    input  logic [31:0]          residual,
    input  logic [1:0]           mode,
    output afsr_pkg::chan_state_t st_out,
    output logic [31:0]          pred_out
);
    afsr_pkg::chan_state_t st_reg, st_next;
    logic [afsr_pkg::TAPS-1:0][31:0] prod_reg, prod_next;
    logic [31:0] res_reg, acc_next, acc_reg, f, t4, t5, t6, p;
    logic [3:0]  fsh, psh;
    logic [1:0]  sgn_in;

    always_comb begin
        st_next = clr ? '0 : st_in;
        for (int i = 0; i < afsr_pkg::TAPS; i++) begin
            if (st_next.sign == 2'b01)
                st_next.weight[i] = st_next.weight[i] + 32'($signed(st_next.step[i]));
            else if (st_next.sign == 2'b11)
                st_next.weight[i] = st_next.weight[i] - 32'($signed(st_next.step[i]));
            prod_next[i] = st_next.hist[i] * st_next.weight[i];
        end
        sgn_in = (residual == '0) ? 2'b00 : (residual[31] ? 2'b11 : 2'b01);
        st_next.sign = sgn_in;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            st_reg   <= st_next;
            prod_reg <= prod_next;
            res_reg  <= residual;
        end
        acc_reg <= acc_next;
    end

    always_comb begin
        unique case (mode)
            afsr_pkg::MODE_8BIT:  begin fsh = 4'd10; psh = 4'd4; end
            afsr_pkg::MODE_16BIT: begin fsh = 4'd9;  psh = 4'd5; end
            default:              begin fsh = 4'd10; psh = 4'd5; end
        endcase
        acc_next = 32'd1 << (fsh - 4'd1);
        for (int i = 0; i < afsr_pkg::TAPS; i++)
            acc_next = acc_next + prod_reg[i];
        f  = res_reg + afsr_pkg::asr32(acc_reg, fsh);
        t6 = f - st_reg.hist[7];
        t5 = t6 - st_reg.hist[6];
        t4 = t5 - st_reg.hist[5];
        p  = f + afsr_pkg::asr32((st_reg.pred << psh) - st_reg.pred, psh);
        st_out = st_reg;
        st_out.step[0] = st_reg.step[1];
        st_out.step[1] = st_reg.step[2];
        st_out.step[2] = st_reg.step[3];
        st_out.step[3] = st_reg.step[4];
        st_out.step[4] = st_reg.hist[4][31] ? 4'hF : 4'h1;
        st_out.step[5] = st_reg.hist[5][31] ? 4'hE : 4'h2;
        st_out.step[6] = st_reg.hist[6][31] ? 4'hE : 4'h2;
        st_out.step[7] = st_reg.hist[7][31] ? 4'hC : 4'h4;
        st_out.hist[0] = st_reg.hist[1];
        st_out.hist[1] = st_reg.hist[2];
        st_out.hist[2] = st_reg.hist[3];
        st_out.hist[3] = st_reg.hist[4];
        st_out.hist[4] = t4;
        st_out.hist[5] = t5;
        st_out.hist[6] = t6;
        st_out.hist[7] = f;
        st_out.pred    = p;
        pred_out       = p;
    end
endmodule

// ----- sv/adaptive_filter_sample_reconstruct.sv -----
// Top level: per-channel adaptive filter, state memory and frame decorrelation.
// A residual that does not end a PCM frame passes these states before the next one can be
// accepted: S_IDLE, the accept step, which also issues the read of the channel's state
// word from a synchronous memory; S_READ, tap weight update and eight multiplies; S_MUL,
// accumulation; S_ACC, which finishes filter and predictor; and S_WB, which writes the
// word back. Only one residual is in flight, so no read can see a stale word. A frame_start
// residual uses all-zero state in place of the memory word and marks other channels stale
// by clearing a valid bit per channel, so no clearing pass is needed. A running sum of
// the held predictions below the last channel is kept as they are written. After the last
// channel of a PCM frame, channel 0's sample is formed from that sum and each following
// sample adds one held prediction, one item per cycle while the receiver does not hold off,
// in channel order through an output register. The input waits while a frame is being
// emitted and until its last sample is taken, so receiver hold-off delays it too.
module adaptive_filter_sample_reconstruct #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_residual,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sample,
    output logic [2:0]  m_channel_index,
    output logic        m_last_of_frame,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    localparam int NCH = (MAX_CHANNELS < afsr_pkg::RESULT_LIMIT) ? MAX_CHANNELS
                                                                 : afsr_pkg::RESULT_LIMIT;
    localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_READ = 6'b000010, S_MUL = 6'b000100,
        S_ACC = 6'b001000, S_WB = 6'b010000, S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [3:0]  count_reg;
    logic [CW-1:0] pos_reg, chan_reg, emit_reg;
    logic [NCH-1:0] live_reg;
    logic [31:0] res_reg;
    logic        fs_reg;
    logic [3:0]  n_act;
    logic [CW-1:0] n_last, pos_eff;
    afsr_pkg::chan_state_t mem [NCH];
    afsr_pkg::chan_state_t rd_reg, st_out;
    logic [31:0] held [NCH];
    logic [31:0] pred_out, acc_s_reg, h_lo;
    logic [31:0] sum_reg, s_first, s_cur;
    logic        clr;

    always_comb begin
        n_act = (count_reg == 4'd0) ? 4'd1 : count_reg;
        if (n_act > 4'(NCH)) n_act = 4'(NCH);
        n_last  = CW'(n_act - 4'd1);
        pos_eff = (4'(pos_reg) >= n_act) ? '0 : pos_reg;
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= afsr_pkg::MODE_16BIT;
            count_reg <= 4'd2;
        end else if (cfg_we) begin
            if (cfg_index == afsr_pkg::REG_MODE) mode_reg <= cfg_data[1:0];
            else                                 count_reg <= cfg_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_READ;
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = S_WB;
            S_WB:   state_next = (chan_reg == n_last) ? S_EMIT : S_IDLE;
            S_EMIT: if (!m_valid || m_ready)
                        state_next = (emit_reg == n_last) ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory read/write, one word per channel.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) rd_reg <= mem[pos_eff];
        if (state_reg == S_WB) begin
            mem[chan_reg]  <= st_out;
            held[chan_reg] <= pred_out;
        end
    end

    assign clr = fs_reg || !live_reg[chan_reg];

    afsr_filter u_filt (
        .aclk(aclk), .start(state_reg == S_READ), .st_in(rd_reg), .clr(clr),
        .residual(res_reg), .mode(mode_reg), .st_out(st_out), .pred_out(pred_out)
    );

    // Decorrelation: top sample minus the sum of lower predictions gives channel 0,
    // then each next channel adds one held prediction.
    always_comb begin
        h_lo = (n_act == 4'd1) ? 32'd0 : held[CW'(n_act - 4'd2)];
        h_lo = afsr_pkg::asr32(h_lo + {31'd0, h_lo[31]}, 4'd1);
        s_first = held[n_last] + h_lo - ((n_act == 4'd1) ? 32'd0 : sum_reg);
        s_cur   = (emit_reg == '0) ? s_first : acc_s_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            live_reg  <= '0;
            emit_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && s_valid && s_ready) begin
                res_reg  <= s_residual;
                fs_reg   <= s_frame_start;
                chan_reg <= s_frame_start ? '0 : pos_eff;
                if (s_frame_start) live_reg <= '0;
            end
            if (state_reg == S_WB) begin
                live_reg[chan_reg] <= 1'b1;
                pos_reg  <= (chan_reg == n_last) ? '0 : chan_reg + 1'b1;
                emit_reg <= '0;
                if (chan_reg != n_last)
                    sum_reg <= ((chan_reg == '0) ? 32'd0 : sum_reg) + pred_out;
            end
            if (state_reg == S_EMIT && (!m_valid || m_ready)) begin
                m_valid         <= 1'b1;
                m_sample        <= s_cur;
                acc_s_reg       <= s_cur + held[emit_reg];
                m_channel_index <= 3'(emit_reg);
                m_last_of_frame <= (emit_reg == n_last);
                emit_reg        <= emit_reg + 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule

// ----- sv/afsr_checker.sv -----
// Port-level checker for the sample reconstruction block, bound to the top level.
`include "adaptive_filter_sample_reconstruct_assert.svh"
module afsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_sample,
    input logic [2:0]  m_channel_index,
    input logic        m_last_of_frame
);
    `AFSR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample))
    `AFSR_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    `AFSR_ASSERT_NEXT(a_idx_zero, aclk, aresetn, m_valid && m_ready && m_last_of_frame, !m_valid || m_channel_index == 3'd0)
endmodule

bind adaptive_filter_sample_reconstruct afsr_checker u_afsr_checker (.*);

// ----- sim/adaptive_filter_sample_reconstruct_tb.sv -----
// Testbench for the sample reconstruction block: table-driven and random residuals checked
// against a behavioral predictor.
`timescale 1ns / 100ps

module adaptive_filter_sample_reconstruct_tb;
    localparam int NCH = 8;
    localparam int NTAP = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [31:0] NOVAL = 32'hDEAD_BEEF;  // row has no typed-in expectation

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_residual = '0;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_sample;
    logic [2:0]  m_channel_index;
    logic        m_last_of_frame;
    logic        cfg_we = 1'b0;
    logic        cfg_index = afsr_pkg::REG_MODE;
    logic [3:0]  cfg_data = '0;

    adaptive_filter_sample_reconstruct dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // One reconstructed sample.
    typedef struct {
        logic [31:0] sample;
        logic [2:0]  chan;
        logic        last;
    } pcm_t;

    pcm_t pending_samples[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    bit   sender_done = 1'b0;
    bit   long_hold = 1'b0;

    // Predictor state.
    logic [1:0]  mode_q;
    logic [3:0]  count_q;
    logic [31:0] weight_q[NCH][NTAP];
    logic [3:0]  step_q[NCH][NTAP];
    logic [31:0] hist_q[NCH][NTAP];
    int          sign_q[NCH];
    logic [31:0] pred_q[NCH];
    logic [31:0] held_q[NCH];
    int          pos_q;

    function automatic logic [31:0] shr_arith(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    task automatic clear_channels();
        for (int c = 0; c < NCH; c++) begin
            for (int i = 0; i < NTAP; i++) begin
                weight_q[c][i] = '0;
                step_q[c][i] = '0;
                hist_q[c][i] = '0;
            end
            sign_q[c] = 0;
            pred_q[c] = '0;
        end
        pos_q = 0;
    endtask

    // Run one residual through the filter and predictor; queue the frame when complete.
    task automatic reconstruct(logic [31:0] res, logic fs);
        int n, fsh, psh, c, sgn;
        logic [31:0] acc, f, p, t4, t5, t6;
        logic [31:0] s[NCH];
        n = (count_q == 0) ? 1 : (count_q > NCH ? NCH : int'(count_q));
        if (fs) clear_channels();
        if (pos_q >= n) pos_q = 0;
        case (mode_q)
            afsr_pkg::MODE_8BIT: begin fsh = 10; psh = 4; end
            afsr_pkg::MODE_16BIT: begin fsh = 9; psh = 5; end
            default: begin fsh = 10; psh = 5; end
        endcase
        c = pos_q;
        sgn = sign_q[c];
        sign_q[c] = (res == 0) ? 0 : (res[31] ? -1 : 1);
        acc = 32'd1 << (fsh - 1);
        for (int i = 0; i < NTAP; i++) begin
            if (sgn > 0) weight_q[c][i] += {{28{step_q[c][i][3]}}, step_q[c][i]};
            else if (sgn < 0) weight_q[c][i] -= {{28{step_q[c][i][3]}}, step_q[c][i]};
            acc += hist_q[c][i] * weight_q[c][i];
        end
        f = res + shr_arith(acc, fsh);
        for (int i = 0; i < 4; i++) step_q[c][i] = step_q[c][i+1];
        step_q[c][4] = hist_q[c][4][31] ? -4'sd1 : 4'sd1;
        step_q[c][5] = hist_q[c][5][31] ? -4'sd2 : 4'sd2;
        step_q[c][6] = hist_q[c][6][31] ? -4'sd2 : 4'sd2;
        step_q[c][7] = hist_q[c][7][31] ? -4'sd4 : 4'sd4;
        t6 = f - hist_q[c][7];
        t5 = t6 - hist_q[c][6];
        t4 = t5 - hist_q[c][5];
        for (int i = 0; i < 4; i++) hist_q[c][i] = hist_q[c][i+1];
        hist_q[c][4] = t4;
        hist_q[c][5] = t5;
        hist_q[c][6] = t6;
        hist_q[c][7] = f;
        p = f + shr_arith((pred_q[c] << psh) - pred_q[c], psh);
        pred_q[c] = p;
        held_q[c] = p;
        if (c + 1 < n) begin
            pos_q = c + 1;
            return;
        end
        pos_q = 0;
        if (n == 1) begin
            s[0] = held_q[0];
        end else begin
            // halving truncates toward zero
            s[n-1] = held_q[n-1] + shr_arith(held_q[n-2] + (held_q[n-2][31] ? 1 : 0), 1);
            for (int i = n - 1; i > 0; i--) s[i-1] = s[i] - held_q[i-1];
        end
        for (int i = 0; i < n; i++)
            pending_samples.push_back('{s[i], 3'(i), (i == n - 1)});
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == afsr_pkg::REG_MODE) mode_q = val[1:0];
        else count_q = val;
    endtask

    // Send one item with a random idle gap; prediction happens at acceptance.
    // Valid stays high across a zero gap; the next payload replaces the accepted one.
    // A typed-in expected sample, when given, must agree with the predictor.
    task automatic send_residual(logic [31:0] res, logic fs, logic [31:0] typed = NOVAL);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_residual <= res;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        reconstruct(res, fs);
        if (typed !== NOVAL && pending_samples.size() > 0 &&
            pending_samples[$].sample !== typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row: expected %h predicted %h", typed,
                    pending_samples[$].sample);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Directed table: residual, frame start, mode, count, typed sample.
    typedef struct {
        logic [31:0] res;
        logic        fs;
        logic [1:0]  mode;
        logic [3:0]  cnt;
        logic [31:0] typed;
    } row_t;

    row_t table_rows[] = '{
        '{32'd0,          1'b1, 2'd1, 4'd1, 32'd0},
        '{32'd5,          1'b0, 2'd1, 4'd1, NOVAL},
        '{32'h7FFF_FFFF,  1'b1, 2'd1, 4'd1, 32'h7FFF_FFFF},
        '{32'h8000_0000,  1'b1, 2'd1, 4'd1, 32'h8000_0000},
        '{32'hFFFF_FFFF,  1'b1, 2'd0, 4'd0, 32'hFFFF_FFFF},
        '{32'd100,        1'b1, 2'd0, 4'd2, NOVAL},
        '{32'hFFFF_FF9C,  1'b0, 2'd0, 4'd2, NOVAL},
        '{32'd3,          1'b0, 2'd2, 4'd2, NOVAL},
        '{32'hFFFF_FFFD,  1'b0, 2'd2, 4'd2, NOVAL},
        '{32'd7,          1'b1, 2'd3, 4'd3, NOVAL},
        '{32'h8000_0000,  1'b0, 2'd3, 4'd3, NOVAL},
        '{32'h7FFF_FFFF,  1'b0, 2'd3, 4'd3, NOVAL},
        '{32'd1,          1'b1, 2'd1, 4'd15, NOVAL},
        '{32'd2,          1'b0, 2'd1, 4'd15, NOVAL},
        '{32'd3,          1'b0, 2'd1, 4'd15, NOVAL},
        '{32'd4,          1'b0, 2'd1, 4'd15, NOVAL},
        '{32'hFFFF_FFF0,  1'b0, 2'd1, 4'd15, NOVAL},
        '{32'd6,          1'b0, 2'd1, 4'd15, NOVAL},
        '{32'd7,          1'b0, 2'd1, 4'd15, NOVAL},
        '{32'd8,          1'b0, 2'd1, 4'd15, NOVAL},
        '{32'd9,          1'b0, 2'd1, 4'd4, NOVAL},
        '{32'd11,         1'b0, 2'd1, 4'd8, NOVAL},
        '{32'd13,         1'b0, 2'd1, 4'd1, NOVAL}    // position restarts when count drops
    };

    initial begin
        logic [1:0] last_mode;
        logic [3:0] last_cnt;
        int n, sent;
        mode_q = afsr_pkg::MODE_16BIT;
        count_q = 4'd2;
        clear_channels();
        for (int c = 0; c < NCH; c++) held_q[c] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part; registers change only with the block idle, at times partway through a frame.
        write_reg(afsr_pkg::REG_MODE, 4'(table_rows[0].mode));
        write_reg(afsr_pkg::REG_COUNT, table_rows[0].cnt);
        foreach (table_rows[r]) begin
            if (table_rows[r].mode != mode_q || table_rows[r].cnt != count_q) begin
                wait_idle();
                if (table_rows[r].mode != mode_q)
                    write_reg(afsr_pkg::REG_MODE, 4'(table_rows[r].mode));
                if (table_rows[r].cnt != count_q)
                    write_reg(afsr_pkg::REG_COUNT, table_rows[r].cnt);
            end
            send_residual(table_rows[r].res, table_rows[r].fs, table_rows[r].typed);
        end

        // Random part: coded frames with random content, each starting with a frame_start residual.
        sent = 0;
        while (sent < 320) begin
            wait_idle();
            last_mode = 2'($urandom_range(0, 3));
            last_cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 4));
            write_reg(afsr_pkg::REG_MODE, 4'(last_mode));
            write_reg(afsr_pkg::REG_COUNT, last_cnt);
            n = (last_cnt == 0) ? 1 : (last_cnt > NCH ? NCH : int'(last_cnt));
            if (sent > 100 && !long_hold) long_hold = 1'b1;
            for (int k = 0; k < n * $urandom_range(2, 6); k++) begin
                logic [31:0] r;
                case ($urandom_range(0, 5))
                    0: r = $urandom;
                    1: r = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
                    2: r = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: r = 32'($signed(16'($urandom)));
                endcase
                send_residual(r, (k == 0) || ($urandom_range(0, 40) == 0));
                sent++;
            end
        end
        s_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // Receiver: random stalls, and at most one long hold-off so the block backs up into its input.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (long_hold == 1'b1 && stall != -1) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                stall = -1;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (stall == 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end
            if (long_hold && stall != -1) stall = -1;
        end
    end

    // Compare each accepted sample with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected sample %h", m_sample);
            end else begin
                pcm_t e;
                e = pending_samples.pop_front();
                if (m_sample !== e.sample || m_channel_index !== e.chan ||
                    m_last_of_frame !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h ch %0d last %b, got %h ch %0d last %b",
                            e.sample, e.chan, e.last, m_sample, m_channel_index,
                            m_last_of_frame);
                end
            end
        end
    end

    // End of run and timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        wait (sender_done);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
